// ===== src/tpdq_pkg.sv =====
// Shared constants, types and helpers for the two-level priority dispatch queue.
`default_nettype none

package tpdq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int TAG_WIDTH   = 32;

  localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int IN_TAG_W  = 32;
  localparam int OUT_TAG_W = 32;
  localparam int BURST_W = 8;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DAT_W = 8;

  localparam logic [BURST_W-1:0] BURST_LIMIT_RST = BURST_W'(4);

  typedef logic [PTR_W-1:0]     ptr_t;
  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [TAG_WIDTH-1:0] tag_t;
  typedef logic [BURST_W-1:0]   burst_t;

  typedef enum logic [1:0] {
    ST_ACCEPTED   = 2'd0,
    ST_REJECTED   = 2'd1,
    ST_DISPATCHED = 2'd2,
    ST_EMPTY      = 2'd3
  } status_t;

  localparam logic FUNC_SUBMIT   = 1'b0;
  localparam logic FUNC_DISPATCH = 1'b1;
  localparam logic PRIO_MEDIUM   = 1'b0;
  localparam logic PRIO_HIGH     = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_BURST_LIMIT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_STOPPED     = CFG_IDX_W'(1);

  // Per-beat decision from the arbiter to the datapath.
  typedef struct packed {
    status_t status;
    logic    push_high;
    logic    push_med;
    logic    pop_high;
    logic    pop_med;
    logic    burst_inc;
    logic    burst_clr;
  } dec_t;

  localparam cnt_t CNT_FULL = CNT_W'(QUEUE_DEPTH);
  localparam ptr_t PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

  function automatic ptr_t ptr_inc(input ptr_t p);
    ptr_t r;
    r = (p == PTR_LAST) ? '0 : p + PTR_W'(1);
    return r;
  endfunction

  function automatic tag_t tag_from_in(input logic [IN_TAG_W-1:0] t);
    logic [63:0] w;
    w = {32'b0, t};
    return w[TAG_WIDTH-1:0];
  endfunction

  function automatic logic [OUT_TAG_W-1:0] tag_to_out(input tag_t t);
    logic [63:0] w;
    w = 64'(t);
    return w[OUT_TAG_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== src/tpdq_if.sv =====
// Channel interfaces: input beats, result beats and configuration writes.
`default_nettype none

interface tpdq_in_if import tpdq_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                func;
  logic                priority_req;
  logic [IN_TAG_W-1:0] task_tag;

  modport source(output valid, func, priority_req, task_tag, input ready);
  modport sink(input valid, func, priority_req, task_tag, output ready);
endinterface

interface tpdq_out_if import tpdq_pkg::*; ();
  logic                 valid;
  logic                 ready;
  status_t              status;
  logic [OUT_TAG_W-1:0] out_tag;
  logic                 from_high;

  modport source(output valid, status, out_tag, from_high, input ready);
  modport sink(input valid, status, out_tag, from_high, output ready);
endinterface

interface tpdq_cfg_if import tpdq_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== src/two_level_priority_dispatch_queue_unit.sv =====
// Top level of the two-level priority dispatch queue.
`default_nettype none

// Two tag FIFOs (high and medium priority) live in synchronous RAMs, one per
// queue; counts, pointers, burst counter and config sit in flops. Each input
// beat is either a submit (func 0) or a dispatch request (func 1) and yields
// exactly one result beat. A submit or any beat that pops nothing (reject,
// empty) has its result loaded into the output register at the accept edge.
// A dispatch that pops goes through the registered read port of the queue
// RAM: the tag is read at accept and lands in the output register the next
// cycle, during which no new beat is taken. Otherwise input is taken whenever
// the output register is free or being drained the same cycle.
// Unwritten RAM entries are never read (counts guard them), so there is no
// clearing pass after reset. Configuration: index 0 burst_limit (reset 4),
// index 1 stopped (reset 0); other indexes are ignored. cfg ready is always
// high; write config only while the block is idle.
module two_level_priority_dispatch_queue_unit import tpdq_pkg::*; (
  input wire logic   clk,
  input wire logic   rst_n,
  tpdq_in_if.sink    in_chan,
  tpdq_out_if.source out_chan,
  tpdq_cfg_if.sink   cfg_chan
);

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_t;

  // config registers
  burst_t burst_limit_r;
  logic   stopped_r;

  // queue bookkeeping
  ptr_t   hi_rd_r, hi_wr_r, md_rd_r, md_wr_r;
  cnt_t   hi_cnt_r, md_cnt_r;
  burst_t burst_r;

  // fsm and output register
  state_t               state_r, state_nxt;
  logic                 pend_high_r, pend_high_nxt;
  logic                 out_valid_r, out_valid_nxt;
  status_t              out_status_r, out_status_nxt;
  logic [OUT_TAG_W-1:0] out_tag_r, out_tag_nxt;
  logic                 out_fh_r, out_fh_nxt;

  logic in_acc;
  logic out_free;
  dec_t dec;
  tag_t hi_q, md_q, wtag;

  assign out_free       = !out_valid_r || out_chan.ready;
  assign in_chan.ready  = (state_r == S_IDLE) && out_free;
  assign in_acc         = in_chan.valid && in_chan.ready;
  assign cfg_chan.ready = 1'b1;

  assign out_chan.valid     = out_valid_r;
  assign out_chan.status    = out_status_r;
  assign out_chan.out_tag   = out_tag_r;
  assign out_chan.from_high = out_fh_r;

  assign wtag = tag_from_in(in_chan.task_tag);

  tpdq_arb u_arb (
    .func         (in_chan.func),
    .priority_req (in_chan.priority_req),
    .stopped      (stopped_r),
    .hi_cnt       (hi_cnt_r),
    .md_cnt       (md_cnt_r),
    .burst_cnt    (burst_r),
    .burst_limit  (burst_limit_r),
    .dec          (dec)
  );

  tpdq_ram #(.DEPTH(QUEUE_DEPTH), .WIDTH(TAG_WIDTH)) u_hi_ram (
    .clk   (clk),
    .we    (in_acc && dec.push_high),
    .waddr (hi_wr_r),
    .wdata (wtag),
    .re    (in_acc && dec.pop_high),
    .raddr (hi_rd_r),
    .rdata (hi_q)
  );

  tpdq_ram #(.DEPTH(QUEUE_DEPTH), .WIDTH(TAG_WIDTH)) u_md_ram (
    .clk   (clk),
    .we    (in_acc && dec.push_med),
    .waddr (md_wr_r),
    .wdata (wtag),
    .re    (in_acc && dec.pop_med),
    .raddr (md_rd_r),
    .rdata (md_q)
  );

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      burst_limit_r <= BURST_LIMIT_RST;
      stopped_r     <= 1'b0;
    end else if (cfg_chan.valid && cfg_chan.ready) begin
      if (cfg_chan.index == CFG_BURST_LIMIT) begin
        burst_limit_r <= cfg_chan.data[BURST_W-1:0];
      end else if (cfg_chan.index == CFG_STOPPED) begin
        stopped_r <= cfg_chan.data[0];
      end
    end
  end

  // pointers, counts and burst counter move at the accept edge,
  // so a pop in flight never races a later access
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hi_rd_r  <= '0;
      hi_wr_r  <= '0;
      md_rd_r  <= '0;
      md_wr_r  <= '0;
      hi_cnt_r <= '0;
      md_cnt_r <= '0;
      burst_r  <= '0;
    end else if (in_acc) begin
      if (dec.push_high) begin
        hi_wr_r  <= ptr_inc(hi_wr_r);
        hi_cnt_r <= hi_cnt_r + CNT_W'(1);
      end
      if (dec.push_med) begin
        md_wr_r  <= ptr_inc(md_wr_r);
        md_cnt_r <= md_cnt_r + CNT_W'(1);
      end
      if (dec.pop_high) begin
        hi_rd_r  <= ptr_inc(hi_rd_r);
        hi_cnt_r <= hi_cnt_r - CNT_W'(1);
      end
      if (dec.pop_med) begin
        md_rd_r  <= ptr_inc(md_rd_r);
        md_cnt_r <= md_cnt_r - CNT_W'(1);
      end
      if (dec.burst_clr) begin
        burst_r <= '0;
      end else if (dec.burst_inc) begin
        burst_r <= burst_r + BURST_W'(1);
      end
    end
  end

  // fsm next state and output register
  always_comb begin
    state_nxt      = state_r;
    pend_high_nxt  = pend_high_r;
    out_valid_nxt  = out_valid_r && !out_chan.ready;
    out_status_nxt = out_status_r;
    out_tag_nxt    = out_tag_r;
    out_fh_nxt     = out_fh_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (dec.pop_high || dec.pop_med) begin
            // tag arrives from RAM next cycle
            state_nxt     = S_READ;
            pend_high_nxt = dec.pop_high;
          end else begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = dec.status;
            out_tag_nxt    = '0;
            out_fh_nxt     = 1'b0;
          end
        end
      end
      S_READ: begin
        state_nxt      = S_IDLE;
        out_valid_nxt  = 1'b1;
        out_status_nxt = ST_DISPATCHED;
        out_tag_nxt    = tag_to_out(pend_high_r ? hi_q : md_q);
        out_fh_nxt     = pend_high_r;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      pend_high_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      pend_high_r <= pend_high_nxt;
    end
    out_status_r <= out_status_nxt;
    out_tag_r    <= out_tag_nxt;
    out_fh_r     <= out_fh_nxt;
  end

  // the output register is always empty while a RAM read is in flight
  a_read_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_READ |-> !out_valid_r)
    else $error("result pending while RAM read in flight");

  // counts never exceed the queue depth
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    hi_cnt_r <= CNT_FULL && md_cnt_r <= CNT_FULL)
    else $error("queue count out of range");

  // a medium pop always restarts the burst
  a_burst_clr: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && dec.pop_med |=> burst_r == '0)
    else $error("burst count not cleared after medium pop");

  // from_high only on a dispatched result
  a_fh_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_fh_r |-> out_status_r == ST_DISPATCHED)
    else $error("from_high set on non-dispatch result");

endmodule

`default_nettype wire

// ===== src/tpdq_ram.sv =====
// Simple dual-port RAM, one write and one registered read port.
`default_nettype none

module tpdq_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== src/tpdq_arb.sv =====
// Strict-priority arbiter with burst limit: decides push, pop and status.
`default_nettype none

module tpdq_arb import tpdq_pkg::*; (
  input  wire logic   func,
  input  wire logic   priority_req,
  input  wire logic   stopped,
  input  wire cnt_t   hi_cnt,
  input  wire cnt_t   md_cnt,
  input  wire burst_t burst_cnt,
  input  wire burst_t burst_limit,
  output dec_t        dec
);

  logic below;
  logic hi_full;
  logic md_full;

  assign below   = burst_cnt < burst_limit;
  assign hi_full = hi_cnt == CNT_FULL;
  assign md_full = md_cnt == CNT_FULL;

  always_comb begin
    dec        = '0;
    dec.status = ST_REJECTED;
    if (func == FUNC_SUBMIT) begin
      priority if (stopped) begin
        dec.status = ST_REJECTED;
      end else if (priority_req == PRIO_HIGH && !hi_full) begin
        dec.push_high = 1'b1;
        dec.status    = ST_ACCEPTED;
      end else if (priority_req == PRIO_MEDIUM && !md_full) begin
        dec.push_med = 1'b1;
        dec.status   = ST_ACCEPTED;
      end else begin
        dec.status = ST_REJECTED;
      end
    end else begin
      priority if (stopped) begin
        dec.status = ST_REJECTED;
      end else if (hi_cnt != '0 && (below || md_cnt == '0)) begin
        dec.pop_high  = 1'b1;
        dec.burst_inc = below;
        dec.status    = ST_DISPATCHED;
      end else if (md_cnt != '0) begin
        dec.pop_med   = 1'b1;
        dec.burst_clr = 1'b1;
        dec.status    = ST_DISPATCHED;
      end else begin
        dec.status = ST_EMPTY;
      end
    end
  end

endmodule

`default_nettype wire

// ===== dv/tb_two_level_priority_dispatch_queue_unit.sv =====
// Self-checking bench for the two-level priority dispatch queue against a queue model.
`default_nettype none

module tb_two_level_priority_dispatch_queue_unit;
  import tpdq_pkg::*;

  // Timeout cap for a hung run; a correct run has about 1100 beats, with idle
  // and stall phases and one long hold-off.
  localparam int LIMIT_CYCLES = 200000;
  localparam int HOLD_CYCLES  = 80;   // long receiver hold-off that backs up the input
  localparam int DRAIN_GAP    = 4;    // extra wait after draining; covers the RAM read of a pop

  typedef struct {
    logic                func;
    logic                prio;
    logic [IN_TAG_W-1:0] tag;
  } req_t;

  typedef struct {
    status_t              status;
    logic [OUT_TAG_W-1:0] tag;
    logic                 from_high;
  } outcome_t;

  logic clk;
  logic rst_n;

  tpdq_in_if  in_chan();
  tpdq_out_if out_chan();
  tpdq_cfg_if cfg_chan();

  two_level_priority_dispatch_queue_unit uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  // Queue model state: both tag FIFOs, the burst counter and the two registers.
  tag_t   hi_q[$];
  tag_t   med_q[$];
  burst_t burst_cnt;
  burst_t burst_lim;
  logic   halted;

  outcome_t outcomes_due[$];  // one entry per accepted beat, oldest first
  req_t     backlog[$];       // beats waiting for the input driver
  req_t     staged[$];        // beats being assembled by the sequence

  int issued_cnt   = 0;
  int accepted_cnt = 0;
  int checked_cnt  = 0;
  int errors       = 0;
  int cycles       = 0;
  int n_submit     = 0;
  int n_dispatch   = 0;
  int n_high_pop   = 0;
  int n_med_pop    = 0;
  int n_reject     = 0;
  int n_empty      = 0;
  int n_cfg        = 0;

  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;
  logic hold_start     = 1'b0;
  int   hold_left      = 0;
  logic in_taken       = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic note_error(input string msg);
    errors++;
    $display("ERROR @%0t: %s", $time, msg);
  endtask

  // Applies one accepted beat to the model and returns the result it must cause.
  task automatic serve_beat(input req_t r, output outcome_t o);
    o = '{ST_EMPTY, '0, 1'b0};
    if (r.func == FUNC_SUBMIT) begin
      n_submit++;
      if (halted) begin
        o.status = ST_REJECTED;
      end else if (r.prio == PRIO_HIGH) begin
        if (hi_q.size() >= QUEUE_DEPTH) begin
          o.status = ST_REJECTED;
        end else begin
          hi_q = {hi_q, tag_t'(r.tag)};
          o.status = ST_ACCEPTED;
        end
      end else begin
        if (med_q.size() >= QUEUE_DEPTH) begin
          o.status = ST_REJECTED;
        end else begin
          med_q = {med_q, tag_t'(r.tag)};
          o.status = ST_ACCEPTED;
        end
      end
    end else begin
      n_dispatch++;
      if (halted) begin
        o.status = ST_REJECTED;
      end else if (hi_q.size() != 0 && (burst_cnt < burst_lim || med_q.size() == 0)) begin
        // high wins while under the burst budget, or when medium has nothing
        o.tag = OUT_TAG_W'(hi_q[0]);
        hi_q.delete(0);
        o.from_high = 1'b1;
        o.status    = ST_DISPATCHED;
        if (burst_cnt < burst_lim)
          burst_cnt = burst_cnt + burst_t'(1);  // saturates at the limit
        n_high_pop++;
      end else if (med_q.size() != 0) begin
        o.tag = OUT_TAG_W'(med_q[0]);
        med_q.delete(0);
        o.status  = ST_DISPATCHED;
        burst_cnt = '0;
        n_med_pop++;
      end else begin
        o.status = ST_EMPTY;
        n_empty++;
      end
    end
    if (o.status == ST_REJECTED)
      n_reject++;
  endtask

  // Rising edge: track register writes, check result beats, predict accepted
  // input beats. The result is checked before the new beat is queued so a
  // beat can never be matched against its own expectation in the same cycle.
  always @(posedge clk) begin
    outcome_t o;
    outcome_t want;
    req_t     r;
    in_taken <= rst_n && in_chan.valid && in_chan.ready;
    if (!rst_n) begin
      hi_q.delete();
      med_q.delete();
      burst_cnt = '0;
      burst_lim = BURST_LIMIT_RST;
      halted    = 1'b0;
    end else begin
      if (cfg_chan.valid && cfg_chan.ready) begin
        n_cfg++;
        if (cfg_chan.index == CFG_BURST_LIMIT)
          burst_lim = burst_t'(cfg_chan.data);
        else if (cfg_chan.index == CFG_STOPPED)
          halted = cfg_chan.data[0];
      end
      if (out_chan.valid && out_chan.ready) begin
        if (outcomes_due.size() == 0) begin
          note_error($sformatf("result with nothing due: status %0d tag %h high %b",
                               out_chan.status, out_chan.out_tag, out_chan.from_high));
        end else begin
          want = outcomes_due[0];
          outcomes_due.delete(0);
          checked_cnt++;
          if (out_chan.status !== want.status)
            note_error($sformatf("beat %0d status %0d, want %0d",
                                 checked_cnt, out_chan.status, want.status));
          if (out_chan.out_tag !== want.tag)
            note_error($sformatf("beat %0d out_tag %h, want %h",
                                 checked_cnt, out_chan.out_tag, want.tag));
          if (out_chan.from_high !== want.from_high)
            note_error($sformatf("beat %0d from_high %b, want %b",
                                 checked_cnt, out_chan.from_high, want.from_high));
        end
      end
      if (in_chan.valid && in_chan.ready) begin
        r = '{in_chan.func, in_chan.priority_req, in_chan.task_tag};
        serve_beat(r, o);
        outcomes_due = {outcomes_due, o};
        accepted_cnt++;
      end
    end
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results still due", cycles, outcomes_due.size());
      $display("two_level_priority_dispatch_queue_unit regression: fail");
      $finish;
    end
  end

  // Input driver: a presented beat stays put until taken; after that the next
  // one goes out unless this cycle is picked as a sender gap.
  always @(negedge clk) begin
    logic v;
    req_t r;
    v = in_chan.valid;
    if (!v || in_taken) begin
      v = 1'b0;
      if (backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        r = backlog[0];
        backlog.delete(0);
        v = 1'b1;
        in_chan.func         <= r.func;
        in_chan.priority_req <= r.prio;
        in_chan.task_tag     <= r.tag;
      end
    end
    in_chan.valid <= v;
  end

  // Receiver: random stalls plus the long hold-off window.
  always @(negedge clk)
    out_chan.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);

  // Hold-off counter, armed by the sequence through hold_start.
  always @(posedge clk) begin
    if (hold_start)
      hold_left <= HOLD_CYCLES;
    else if (hold_left != 0)
      hold_left <= hold_left - 1;
  end

  function automatic req_t mk(input logic f, input logic p, input logic [IN_TAG_W-1:0] t);
    req_t r;
    r = '{f, p, t};
    return r;
  endfunction

  function automatic req_t random_req(input int submit_pct, input int high_pct);
    req_t r;
    r.func = ($urandom_range(99) < submit_pct) ? FUNC_SUBMIT : FUNC_DISPATCH;
    r.prio = ($urandom_range(99) < high_pct) ? PRIO_HIGH : PRIO_MEDIUM;
    case ($urandom_range(15))
      0:       r.tag = '0;
      1:       r.tag = '1;
      default: r.tag = $urandom;
    endcase
    return r;
  endfunction

  // Appends one beat to the set being assembled.
  task automatic stage_beat(input req_t r);
    staged = {staged, r};
  endtask

  // Hands the staged beats to the driver on a rising edge, together with the
  // idle/stall mix for this phase.
  task automatic release_staged(input int idle_pct, input int stall_pct);
    @(posedge clk);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    backlog = {backlog, staged};
    issued_cnt += staged.size();
    staged.delete();
  endtask

  // Every beat gives exactly one result, so once all are taken and checked
  // the block is idle; the short gap covers the pop pipeline anyway.
  task automatic wait_drained;
    do @(negedge clk);
    while (accepted_cnt != issued_cnt || outcomes_due.size() != 0);
    repeat (DRAIN_GAP) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
    @(negedge clk);
    cfg_chan.index = idx;
    cfg_chan.data  = val;
    cfg_chan.valid = 1'b1;
    do @(posedge clk);
    while (cfg_chan.ready !== 1'b1);
    @(negedge clk);
    cfg_chan.valid = 1'b0;
  endtask

  // Random traffic in chunks of 20 beats; each chunk picks its own submit
  // and priority bias so queues swing between empty, mixed and full.
  task automatic random_phase(input int n, input int idle_pct, input int stall_pct);
    int submit_pct;
    int high_pct;
    submit_pct = 50;
    high_pct   = 50;
    for (int i = 0; i < n; i++) begin
      if (i % 20 == 0) begin
        case ($urandom_range(3))
          0:       submit_pct = 20;
          1:       submit_pct = 50;
          2:       submit_pct = 65;
          default: submit_pct = 90;
        endcase
        case ($urandom_range(2))
          0:       high_pct = 10;
          1:       high_pct = 50;
          default: high_pct = 90;
        endcase
      end
      stage_beat(random_req(submit_pct, high_pct));
    end
    release_staged(idle_pct, stall_pct);
  endtask

  initial begin
    rst_n                = 1'b0;
    in_chan.valid        = 1'b0;
    in_chan.func         = FUNC_SUBMIT;
    in_chan.priority_req = PRIO_MEDIUM;
    in_chan.task_tag     = '0;
    out_chan.ready       = 1'b0;
    cfg_chan.valid       = 1'b0;
    cfg_chan.index       = CFG_BURST_LIMIT;
    cfg_chan.data        = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed, reset config (limit 4, running): dispatch from empty, fill
    // the high queue past full with extreme tags, one medium task, then
    // enough dispatches to hit the burst limit and force the medium pop.
    stage_beat(mk(FUNC_DISPATCH, PRIO_HIGH, '1));
    stage_beat(mk(FUNC_SUBMIT, PRIO_HIGH, '0));
    stage_beat(mk(FUNC_SUBMIT, PRIO_HIGH, '1));
    repeat (14) stage_beat(mk(FUNC_SUBMIT, PRIO_HIGH, $urandom));
    stage_beat(mk(FUNC_SUBMIT, PRIO_HIGH, 32'h5a5a_a5a5));   // high queue full
    stage_beat(mk(FUNC_SUBMIT, PRIO_MEDIUM, 32'h8000_0001));
    repeat (6) stage_beat(mk(FUNC_DISPATCH, PRIO_MEDIUM, '0));
    release_staged(0, 0);

    // Stopped: submits of both priorities and a dispatch are all rejected.
    wait_drained;
    write_reg(CFG_STOPPED, 8'd1);
    stage_beat(mk(FUNC_SUBMIT, PRIO_MEDIUM, '1));
    stage_beat(mk(FUNC_SUBMIT, PRIO_HIGH, '0));
    stage_beat(mk(FUNC_DISPATCH, PRIO_HIGH, '0));
    release_staged(0, 0);

    wait_drained;
    write_reg(CFG_STOPPED, 8'd0);
    write_reg(CFG_BURST_LIMIT, 8'd1);
    random_phase(150, 0, 0);

    wait_drained;
    write_reg(CFG_BURST_LIMIT, 8'd255);
    random_phase(130, 51, 0);

    // Limit 0: high served only when medium is empty.
    wait_drained;
    write_reg(CFG_BURST_LIMIT, 8'd0);
    random_phase(130, 0, 51);

    wait_drained;
    write_reg(CFG_STOPPED, 8'd1);
    random_phase(30, 10, 10);

    wait_drained;
    write_reg(CFG_STOPPED, 8'd0);
    write_reg(CFG_BURST_LIMIT, 8'd2);
    random_phase(130, 10, 10);

    // Back-pressure: receiver holds off while the sender keeps offering.
    wait_drained;
    write_reg(CFG_BURST_LIMIT, 8'($urandom_range(3, 20)));
    @(negedge clk);
    hold_start = 1'b1;
    @(negedge clk);
    hold_start = 1'b0;
    random_phase(150, 0, 0);

    // Let the burst count climb, then drop the limit below it.
    wait_drained;
    write_reg(CFG_BURST_LIMIT, 8'd255);
    random_phase(120, 0, 51);
    wait_drained;
    write_reg(CFG_BURST_LIMIT, 8'd1);
    random_phase(100, 10, 10);

    wait_drained;
    write_reg(CFG_BURST_LIMIT, 8'($urandom_range(1, 255)));
    random_phase(100, 51, 0);

    wait_drained;
    repeat (8) @(negedge clk);

    $display("covered %0d beats (%0d submits, %0d dispatches), %0d results checked",
             accepted_cnt, n_submit, n_dispatch, checked_cnt);
    $display("  %0d high pops, %0d medium pops, %0d rejects, %0d empty, %0d register writes",
             n_high_pop, n_med_pop, n_reject, n_empty, n_cfg);
    if (errors == 0)
      $display("two_level_priority_dispatch_queue_unit regression: pass");
    else
      $display("two_level_priority_dispatch_queue_unit regression: fail");
    $finish;
  end

endmodule

`default_nettype wire
